FILE: sv/pns_pkg.sv
// shared types and constants for the priority scheduler
package pns_pkg;

  localparam int MaxProcs = 16;
  localparam int IdW      = 8;
  localparam int PrioW    = 8;
  localparam int BurstW   = 16;
  localparam int TimeW    = 20;
  localparam int TotalW   = 24;
  localparam int CntW     = $clog2(MaxProcs + 1);
  localparam int AccW     = TimeW + $clog2(MaxProcs);
  localparam int TotAccW  = TotalW + $clog2(MaxProcs);

  localparam logic [TimeW-1:0]  TimeMax  = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef struct packed {
    logic [IdW-1:0]    process_id;
    logic [PrioW-1:0]  priority_req;
    logic [BurstW-1:0] burst_time;
    logic              last;
  } pns_in_t;

  typedef struct packed {
    logic [IdW-1:0]    process_id_res;
    logic [PrioW-1:0]  priority_res;
    logic [BurstW-1:0] burst_time_res;
    logic [TimeW-1:0]  wait_time;
    logic [TimeW-1:0]  turnaround_time;
    logic [TotalW-1:0] total_wait;
    logic [TotalW-1:0] total_turnaround;
    logic              overflow;
    logic              last_res;
  } pns_out_t;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
  } entry_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_entry;
    logic out_free;
  } status_t;

endpackage

FILE: sv/priority_nonpreemptive_scheduler.sv
// top level: non-preemptive priority scheduler
// load phase takes one item per cycle, kept sorted by a row of insertion cells
// after the item marked last, the controller enters its emission state and results leave through
// the result register, one per cycle while the output is taken, n results for n stored items
// inputs are held off during emission; the next set loads as the last result waits
// reset clears entry count, overflow flag, accumulators and result valid
module priority_nonpreemptive_scheduler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pns_pkg::pns_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pns_pkg::pns_out_t out_o
);
  import pns_pkg::*;

  cmd_t    cmd;
  status_t status;

  pns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_i.last),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pns_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

FILE: sv/pns_sort_array.sv
// insertion sort array of process entries, head holds lowest priority value
module pns_sort_array (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            pop_i,
  input  pns_pkg::entry_t entry_i,
  output pns_pkg::entry_t head_o,
  output logic            full_o,
  output logic            last_entry_o
);
  import pns_pkg::*;

  entry_t            cell_q [MaxProcs];
  entry_t            cell_d [MaxProcs];
  logic [CntW-1:0]   count_q, count_d;
  logic [MaxProcs-1:0] gt;

  assign full_o       = (count_q == CntW'(MaxProcs));
  assign last_entry_o = (count_q == CntW'(1));
  assign head_o       = cell_q[0];

  // empty cells count as greater so the new entry lands behind all equal ones
  always_comb begin
    for (int i = 0; i < MaxProcs; i++) begin
      gt[i] = (CntW'(i) >= count_q) || (cell_q[i].prio > entry_i.prio);
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < MaxProcs; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (load_i && !full_o) begin
      count_d = count_q + CntW'(1);
      for (int i = 0; i < MaxProcs; i++) begin
        if (gt[i]) begin
          if (i == 0) begin
            cell_d[i] = entry_i;
          end else if (gt[i-1]) begin
            cell_d[i] = cell_q[i-1];
          end else begin
            cell_d[i] = entry_i;
          end
        end
      end
    end else if (pop_i) begin
      count_d = count_q - CntW'(1);
      for (int i = 0; i < MaxProcs - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxProcs; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

endmodule

FILE: sv/pns_datapath.sv
// datapath: sorted store, wait and turnaround accumulators, result register
module pns_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pns_pkg::pns_in_t  in_i,
  input  pns_pkg::cmd_t     cmd_i,
  output pns_pkg::status_t  status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output pns_pkg::pns_out_t out_o
);
  import pns_pkg::*;

  entry_t              new_entry, head;
  logic                full, last_entry;
  logic                ovf_q, ovf_d;
  logic [AccW-1:0]     wait_q, wait_d;
  logic [TotAccW-1:0]  tot_w_q, tot_w_d, tot_t_q, tot_t_d;
  logic [AccW:0]       turn_sum;
  logic [TimeW-1:0]    w_sat, t_sat;
  logic                out_valid_q, out_valid_d;
  pns_out_t            out_q, out_d;

  assign new_entry = '{id: in_i.process_id, prio: in_i.priority_req,
                       burst: in_i.burst_time};

  pns_sort_array u_sort (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (cmd_i.load),
    .pop_i        (cmd_i.pop),
    .entry_i      (new_entry),
    .head_o       (head),
    .full_o       (full),
    .last_entry_o (last_entry)
  );

  assign status_o.last_entry = last_entry;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    turn_sum = {1'b0, wait_q} + (AccW + 1)'(head.burst);
    w_sat    = (wait_q > AccW'(TimeMax)) ? TimeMax : wait_q[TimeW-1:0];
    t_sat    = (turn_sum > (AccW + 1)'(TimeMax)) ? TimeMax : turn_sum[TimeW-1:0];
    tot_w_d  = tot_w_q + TotAccW'(w_sat);
    tot_t_d  = tot_t_q + TotAccW'(t_sat);
    wait_d   = wait_q + AccW'(head.burst);

    ovf_d = ovf_q;
    if (cmd_i.load && full) begin
      ovf_d = 1'b1;
    end

    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.pop) begin
      out_valid_d            = 1'b1;
      out_d.process_id_res   = head.id;
      out_d.priority_res     = head.prio;
      out_d.burst_time_res   = head.burst;
      out_d.wait_time        = w_sat;
      out_d.turnaround_time  = t_sat;
      out_d.total_wait       = '0;
      out_d.total_turnaround = '0;
      out_d.overflow         = ovf_q;
      out_d.last_res         = cmd_i.finish;
      if (cmd_i.finish) begin
        out_d.total_wait = (tot_w_d > TotAccW'(TotalMax)) ? TotalMax
                                                          : tot_w_d[TotalW-1:0];
        out_d.total_turnaround = (tot_t_d > TotAccW'(TotalMax)) ? TotalMax
                                                                : tot_t_d[TotalW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q       <= 1'b0;
      wait_q      <= '0;
      tot_w_q     <= '0;
      tot_t_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.finish) begin
        ovf_q   <= 1'b0;
        wait_q  <= '0;
        tot_w_q <= '0;
        tot_t_q <= '0;
      end else begin
        ovf_q <= ovf_d;
        if (cmd_i.pop) begin
          wait_q  <= wait_d;
          tot_w_q <= tot_w_d;
          tot_t_q <= tot_t_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: sv/pns_ctrl.sv
// controller: load phase and emission phase sequencing
module pns_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  pns_pkg::status_t status_i,
  output pns_pkg::cmd_t    cmd_o
);
  import pns_pkg::*;

  typedef enum logic {
    StLoad,
    StEmit
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == StLoad);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.pop   = (state_q == StEmit) && status_i.out_free;
  assign cmd_o.finish = cmd_o.pop && status_i.last_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      unique case (state_q)
        StLoad: begin
          if (cmd_o.load && in_last_i) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (cmd_o.finish) begin
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

FILE: sim/pns_checker.sv
// checker for the priority scheduler: predicts each set's service order and compares results
module pns_checker
  import pns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  pns_in_t  in_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  pns_out_t out_i,
  output int       errors_o,
  output int       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t   loaded[MaxProcs];
  int       loaded_cnt = 0;
  bit       dropped = 1'b0;
  pns_out_t service_q[$];
  int       err_cnt = 0;

  function automatic void queue_service_order();
    entry_t   order[MaxProcs];
    entry_t   key;
    longint   waited, tot_w, tot_t, w, t;
    pns_out_t res;
    int       j;
    order = loaded;
    for (int i = 1; i < loaded_cnt; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && order[j-1].prio > key.prio) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    waited = 0;
    tot_w  = 0;
    tot_t  = 0;
    for (int i = 0; i < loaded_cnt; i++) begin
      w = (waited > longint'(TimeMax)) ? longint'(TimeMax) : waited;
      t = waited + order[i].burst;
      if (t > longint'(TimeMax)) t = longint'(TimeMax);
      tot_w += w;
      tot_t += t;
      res = '0;
      res.process_id_res  = order[i].id;
      res.priority_res    = order[i].prio;
      res.burst_time_res  = order[i].burst;
      res.wait_time       = TimeW'(w);
      res.turnaround_time = TimeW'(t);
      res.overflow        = dropped;
      if (i == loaded_cnt - 1) begin
        res.total_wait       = (tot_w > longint'(TotalMax)) ? TotalMax : TotalW'(tot_w);
        res.total_turnaround = (tot_t > longint'(TotalMax)) ? TotalMax : TotalW'(tot_t);
        res.last_res         = 1'b1;
      end
      service_q.push_back(res);
      waited += order[i].burst;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    pns_out_t want;
    if (!rst_ni) begin
      loaded_cnt = 0;
      dropped    = 1'b0;
      service_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (service_q.size() == 0) begin
          $error("result with nothing expected: process_id_res %0d", out_i.process_id_res);
          err_cnt++;
        end else begin
          want = service_q.pop_front();
          check_field("process_id_res", want.process_id_res, out_i.process_id_res);
          check_field("priority_res", want.priority_res, out_i.priority_res);
          check_field("burst_time_res", want.burst_time_res, out_i.burst_time_res);
          check_field("wait_time", want.wait_time, out_i.wait_time);
          check_field("turnaround_time", want.turnaround_time, out_i.turnaround_time);
          check_field("total_wait", want.total_wait, out_i.total_wait);
          check_field("total_turnaround", want.total_turnaround, out_i.total_turnaround);
          check_field("overflow", want.overflow, out_i.overflow);
          check_field("last_res", want.last_res, out_i.last_res);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (loaded_cnt < MaxProcs) begin
          loaded[loaded_cnt] = {in_i.process_id, in_i.priority_req, in_i.burst_time};
          loaded_cnt++;
        end else begin
          dropped = 1'b1;
        end
        if (in_i.last) begin
          queue_service_order();
          loaded_cnt = 0;
          dropped    = 1'b0;
        end
      end
    end
    errors_o      <= err_cnt;
    outstanding_o <= service_q.size();
  end

endmodule

FILE: sim/priority_nonpreemptive_scheduler_tb.sv
// testbench top for the priority scheduler: stimulus, handshake idling and verdict
module priority_nonpreemptive_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pns_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pns_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pns_out_t out_item;
  bit       steady = 1'b0;
  int       errors;
  int       outstanding;
  int       sent = 0;

  priority_nonpreemptive_scheduler u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  pns_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_item),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  task automatic send_process(input logic [7:0] id, input logic [7:0] prio,
                              input logic [15:0] burst, input logic last);
    while (!steady && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{process_id: id, priority_req: prio, burst_time: burst, last: last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_random_set();
    int          n;
    bit          ties;
    logic [7:0]  p;
    logic [15:0] b;
    n    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    ties = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      p = ties ? 8'($urandom_range(0, 3)) : 8'($urandom);
      case ($urandom_range(0, 5))
        0: b = '0;
        1: b = '1;
        default: b = 16'($urandom);
      endcase
      send_process(8'($urandom), p, b, i == n - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single process, all fields at their top
    send_process(8'hff, 8'hff, 16'hffff, 1'b1);
    // equal priorities keep load order, zero bursts
    send_process(8'd0, 8'd0, 16'd0, 1'b0);
    send_process(8'd1, 8'hff, 16'hffff, 1'b0);
    send_process(8'd2, 8'd0, 16'd1, 1'b0);
    send_process(8'd3, 8'hff, 16'd0, 1'b1);
    // table full, the closing item is dropped
    for (int i = 0; i < MaxProcs + 1; i++) begin
      send_process(8'(i + 16), 8'((MaxProcs - i) / 2), 16'hffff, i == MaxProcs);
    end

    while (sent < 130) begin
      steady <= (sent >= 45 && sent < 85);
      send_random_set();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: priority_nonpreemptive_scheduler.f
sv/pns_pkg.sv
sv/pns_sort_array.sv
sv/pns_datapath.sv
sv/pns_ctrl.sv
sv/priority_nonpreemptive_scheduler.sv
sim/pns_checker.sv
sim/priority_nonpreemptive_scheduler_tb.sv
